/* rtl/bht_pkg.sv */
// bht_pkg: shared widths and codes for the bucketed hash table.
// No dependencies; imported by bht_mod and bucketed_hash_table.
package bht_pkg;

    localparam int KEY_W     = 31;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;
    localparam int IDX_OUT_W = 7;
    localparam int CNT_OUT_W = 7;

    // stream widths
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = OP_W;
    localparam int M_TDATA_W = 24;

    // key residue: key times a KEY_W + 1 bit reciprocal
    localparam int PROD_W    = 2 * KEY_W + 1;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
    localparam logic [OP_W-1:0] OP_COUNT  = 2'd3;

    localparam logic [STATUS_W-1:0] STS_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STS_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STS_MISSING = 2'd2;

endpackage

/* rtl/bht_mod.sv */
// bht_mod: key mod BUCKET_COUNT by reciprocal multiplication.
// Depends on bht_pkg.
module bht_mod #(
    parameter int BUCKET_COUNT = 10,
    parameter int REM_W        = 4
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [bht_pkg::KEY_W-1:0] key,
    output logic                      done,
    output logic [REM_W-1:0]          rem
);
    import bht_pkg::*;

    // quotient = (key * MUL) >> SH, exact for every key below 2**KEY_W
    localparam int SH = KEY_W + $clog2(BUCKET_COUNT);
    localparam logic [63:0] MUL_WIDE =
        ((64'd1 << SH) + 64'(BUCKET_COUNT) - 64'd1) / 64'(BUCKET_COUNT);
    localparam logic [KEY_W:0]   MUL   = MUL_WIDE[KEY_W:0];
    localparam logic [KEY_W-1:0] DIV_K = KEY_W'(BUCKET_COUNT);

    logic [KEY_W-1:0]  key_reg, key_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [KEY_W-1:0]  qd_reg, qd_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic              p1_reg;
    logic              p2_reg;
    logic              done_reg;
    logic [KEY_W-1:0]  quo;
    logic [KEY_W-1:0]  diff;

    // stage 1: product, stage 2: quotient times divisor, stage 3: remainder
    always_comb
    begin
        quo       = KEY_W'(prod_reg >> SH);
        diff      = key_reg - qd_reg;
        key_next  = key_reg;
        prod_next = prod_reg;
        qd_next   = qd_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            key_next  = key;
            prod_next = PROD_W'(key) * PROD_W'(MUL);
        end
        if (p1_reg)
        begin
            qd_next = quo * DIV_K;
        end
        if (p2_reg)
        begin
            rem_next = diff[REM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg   <= 1'b0;
            p2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            p1_reg   <= start;
            p2_reg   <= p1_reg;
            done_reg <= p2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        prod_reg <= prod_next;
        qd_reg   <= qd_next;
        rem_reg  <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

/* rtl/bucketed_hash_table.sv */
// bucketed_hash_table: key table of TABLE_SLOTS slots probed per bucket.
// Depends on bht_pkg and bht_mod.
//
//  port group | dir | tdata (low bit up)                           | tuser
//  s_axis     | in  | store_key[30:0], pad[31]                     | operation[1:0]
//  m_axis     | out | status[1:0], found[2], slot_index[9:3],      | -
//             |     | entry_count[16:10], pad[23:17]               |
//
// Flow: one beat in, one beat out. Count goes straight to the output register;
// insert, search and delete first take the key residue by reciprocal multiply
// in bht_mod, then probe the bucket's slots (one memory read a cycle, data the
// cycle after), then load the output register.
// Reset: after rst_n releases, a clearing pass writes every slot invalid, with
// s_axis_tready low throughout.
// Stalls: a result waits in the output register while the next beat is
// taken; the block holds in S_FINISH only while that register is full and m_axis_tready is low.
module bucketed_hash_table #(
    parameter int BUCKET_COUNT = 10,
    parameter int TABLE_SLOTS  = 100
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // store_key[30:0], zero pad [31]
    input  logic [bht_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // operation[1:0]
    input  logic [bht_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // status[1:0], found[2], slot_index[9:3], entry_count[16:10], zero pad
    output logic [bht_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import bht_pkg::*;

    localparam int ADDR_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int PW     = $clog2(TABLE_SLOTS + BUCKET_COUNT);
    localparam int REM_W  = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
    localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);
    localparam int ENT_W  = KEY_W + 1;   // {valid, key}

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_PROBE,
        S_FINISH
    } state_t;

    state_t               state_reg, state_next;
    logic [OP_W-1:0]      op_reg, op_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [PW-1:0]        iss_reg, iss_next;        // next slot to read
    logic [ADDR_W-1:0]    chk_reg, chk_next;        // slot whose data is back
    logic                 chk_vld_reg, chk_vld_next;
    logic [ADDR_W-1:0]    clr_reg, clr_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [STATUS_W-1:0]  sts_reg, sts_next;
    logic                 hit_reg, hit_next;
    logic [ADDR_W-1:0]    slot_reg, slot_next;
    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    logic                 mod_start;
    logic                 mod_done;
    logic [REM_W-1:0]     mod_rem;

    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_wa;
    logic [ENT_W-1:0]     mem_wd;
    logic [ADDR_W-1:0]    mem_ra;
    logic [ENT_W-1:0]     rd_data;
    logic [ENT_W-1:0]     slot_mem [TABLE_SLOTS];

    logic                 iss_in;
    logic                 probe_hit;
    logic [31:0]          slot_ext;
    logic [31:0]          cnt_ext;

    bht_mod #(
        .BUCKET_COUNT (BUCKET_COUNT),
        .REM_W        (REM_W)
    ) u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start),
        .key   (s_axis_tdata[KEY_W-1:0]),
        .done  (mod_done),
        .rem   (mod_rem)
    );

    // slot store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_wa] <= mem_wd;
        end
        rd_data <= slot_mem[mem_ra];
    end

    assign iss_in = (iss_reg < PW'(TABLE_SLOTS));

    // insert wants the first free slot, search/delete the first live match
    always_comb
    begin
        if (op_reg == OP_INSERT)
        begin
            probe_hit = chk_vld_reg && !rd_data[KEY_W];
        end
        else
        begin
            probe_hit = chk_vld_reg && rd_data[KEY_W] &&
                        (rd_data[KEY_W-1:0] == key_reg);
        end
    end

    assign slot_ext = 32'(slot_reg);
    assign cnt_ext  = 32'(cnt_reg);

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        iss_next     = iss_reg;
        chk_next     = chk_reg;
        chk_vld_next = chk_vld_reg;
        clr_next     = clr_reg;
        cnt_next     = cnt_reg;
        sts_next     = sts_reg;
        hit_next     = hit_reg;
        slot_next    = slot_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        mod_start    = 1'b0;
        mem_we       = 1'b0;
        mem_wa       = chk_reg;
        mem_wd       = '0;
        mem_ra       = iss_reg[ADDR_W-1:0];

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_wa   = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(TABLE_SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next   = s_axis_tuser;
                    key_next  = s_axis_tdata[KEY_W-1:0];
                    sts_next  = STS_DONE;
                    hit_next  = 1'b0;
                    slot_next = '0;
                    if (s_axis_tuser == OP_COUNT)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        mod_start  = 1'b1;
                        state_next = S_MOD;
                    end
                end
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    iss_next     = PW'(mod_rem);
                    chk_vld_next = 1'b0;
                    state_next   = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (probe_hit)
                begin
                    slot_next    = chk_reg;
                    sts_next     = STS_DONE;
                    hit_next     = (op_reg != OP_INSERT);
                    chk_vld_next = 1'b0;
                    state_next   = S_FINISH;
                    if (op_reg == OP_INSERT)
                    begin
                        mem_we   = 1'b1;
                        mem_wd   = {1'b1, key_reg};
                        cnt_next = cnt_reg + 1'b1;
                    end
                    else if (op_reg == OP_DELETE)
                    begin
                        mem_we   = 1'b1;
                        mem_wd   = {1'b0, key_reg};
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
                else if (!chk_vld_reg && !iss_in)
                begin
                    // probe sequence exhausted
                    sts_next   = (op_reg == OP_INSERT) ? STS_FULL : STS_MISSING;
                    state_next = S_FINISH;
                end
                else if (iss_in)
                begin
                    chk_next     = iss_reg[ADDR_W-1:0];
                    chk_vld_next = 1'b1;
                    iss_next     = iss_reg + PW'(BUCKET_COUNT);
                end
                else
                begin
                    chk_vld_next = 1'b0;
                end
            end
            S_FINISH:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {(M_TDATA_W - STATUS_W - 1 - IDX_OUT_W - CNT_OUT_W)'(0),
                                    cnt_ext[CNT_OUT_W-1:0], slot_ext[IDX_OUT_W-1:0],
                                    hit_reg, sts_reg};
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            cnt_reg     <= '0;
            chk_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            cnt_reg     <= cnt_next;
            chk_vld_reg <= chk_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        iss_reg    <= iss_next;
        chk_reg    <= chk_next;
        sts_reg    <= sts_next;
        hit_reg    <= hit_next;
        slot_reg   <= slot_next;
        m_data_reg <= m_data_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(TABLE_SLOTS))
        else $error("valid count above table size");

    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(state_reg == S_FINISH))
        else $error("result raised outside finish");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_CLEAR || state_reg == S_PROBE))
        else $error("slot write outside clear or probe");

    a_cnt_moves_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |-> $past(mem_we && state_reg == S_PROBE))
        else $error("count changed without a slot write");

endmodule
